// File: src/npc_pkg.sv
// Package: palette table, widths, types and helpers for the nearest palette colour block
package npc_pkg;

  localparam int PALETTE_SIZE = 20;
  localparam int TABLE_LEN    = 20;
  localparam int NUM_ENTRIES  = (PALETTE_SIZE > TABLE_LEN) ? TABLE_LEN :
                                ((PALETTE_SIZE < 1) ? 1 : PALETTE_SIZE);

  localparam int CH_W   = 8;
  localparam int SQ_W   = 2 * CH_W;
  localparam int DIST_W = 18;
  localparam int IDX_W  = 5;

  localparam int TREE_LVLS  = $clog2(NUM_ENTRIES);
  localparam int PIPE_DEPTH = TREE_LVLS + 3;

  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [SQ_W-1:0]   sq_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
  } rgb_t;

  localparam rgb_t PALETTE [TABLE_LEN] = '{
    '{8'd255, 8'd0,   8'd0  }, '{8'd0,   8'd255, 8'd0  },
    '{8'd0,   8'd0,   8'd255}, '{8'd255, 8'd255, 8'd0  },
    '{8'd0,   8'd255, 8'd255}, '{8'd255, 8'd0,   8'd255},
    '{8'd255, 8'd255, 8'd255}, '{8'd0,   8'd0,   8'd0  },
    '{8'd255, 8'd165, 8'd0  }, '{8'd128, 8'd0,   8'd128},
    '{8'd255, 8'd192, 8'd203}, '{8'd50,  8'd205, 8'd50 },
    '{8'd0,   8'd128, 8'd128}, '{8'd0,   8'd0,   8'd128},
    '{8'd128, 8'd0,   8'd0  }, '{8'd128, 8'd128, 8'd0  },
    '{8'd128, 8'd128, 8'd128}, '{8'd192, 8'd192, 8'd192},
    '{8'd139, 8'd69,  8'd19 }, '{8'd255, 8'd215, 8'd0  }
  };

  // Candidates left after lvl halving steps of the minimum tree
  function automatic int level_count(int lvl);
    return (NUM_ENTRIES + (1 << lvl) - 1) >> lvl;
  endfunction

  function automatic sq_t sq_diff(chan_t a, chan_t b);
    chan_t d;
    d = (a >= b) ? (a - b) : (b - a);
    return {{CH_W{1'b0}}, d} * {{CH_W{1'b0}}, d};
  endfunction

endpackage

// File: src/npc_if.sv
// Interfaces: colour item channel and palette match result channel
interface npc_in_if import npc_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface npc_out_if import npc_pkg::*; ();
  logic  valid;
  logic  ready;
  idx_t  palette_index;
  dist_t min_distance;

  modport source (output valid, output palette_index, output min_distance, input ready);
  modport sink   (input valid, input palette_index, input min_distance, output ready);
endinterface

// File: src/npc_dist.sv
// Distance pipeline: per-entry squared channel differences, then their sums
module npc_dist import npc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  rgb_t  in_rgb,
  output logic  dist_valid,
  input  logic  dist_ready,
  output dist_t entry_dist [NUM_ENTRIES]
);

  logic  sq_valid_r;
  logic  sq_ready;
  sq_t   sq_r_r   [NUM_ENTRIES];
  sq_t   sq_g_r   [NUM_ENTRIES];
  sq_t   sq_b_r   [NUM_ENTRIES];
  sq_t   sq_r_nxt [NUM_ENTRIES];
  sq_t   sq_g_nxt [NUM_ENTRIES];
  sq_t   sq_b_nxt [NUM_ENTRIES];
  logic  sum_valid_r;
  dist_t sum_r    [NUM_ENTRIES];
  dist_t sum_nxt  [NUM_ENTRIES];

  assign sq_ready = !sum_valid_r || dist_ready;
  assign in_ready = !sq_valid_r || sq_ready;

  always_comb begin
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      sq_r_nxt[k] = sq_diff(in_rgb.r, PALETTE[k].r);
      sq_g_nxt[k] = sq_diff(in_rgb.g, PALETTE[k].g);
      sq_b_nxt[k] = sq_diff(in_rgb.b, PALETTE[k].b);
      sum_nxt[k]  = DIST_W'(sq_r_r[k]) + DIST_W'(sq_g_r[k]) + DIST_W'(sq_b_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r  <= 1'b0;
      sum_valid_r <= 1'b0;
    end else begin
      if (in_ready) sq_valid_r <= in_valid;
      if (sq_ready) sum_valid_r <= sq_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sq_r_r <= sq_r_nxt;
      sq_g_r <= sq_g_nxt;
      sq_b_r <= sq_b_nxt;
    end
    if (sq_ready && sq_valid_r) begin
      sum_r <= sum_nxt;
    end
  end

  assign dist_valid = sum_valid_r;
  assign entry_dist = sum_r;

endmodule

// File: src/npc_min_tree.sv
// Registered pairwise minimum tree over the entry distances, lower index kept on ties
module npc_min_tree import npc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  dist_t in_dist [NUM_ENTRIES],
  output logic  out_valid,
  input  logic  out_ready,
  output idx_t  out_idx,
  output dist_t out_dist
);

  dist_t lvl_dist [TREE_LVLS+1][NUM_ENTRIES];
  idx_t  lvl_idx  [TREE_LVLS+1][NUM_ENTRIES];
  logic  lvl_vld  [TREE_LVLS+1];
  logic  lvl_rdy  [TREE_LVLS+1];

  genvar l, i;

  generate
    for (i = 0; i < NUM_ENTRIES; i++) begin : g_leaf
      assign lvl_dist[0][i] = in_dist[i];
      assign lvl_idx[0][i]  = IDX_W'(i);
    end

    for (l = 1; l <= TREE_LVLS; l++) begin : g_lvl
      localparam int CNT  = level_count(l);
      localparam int PCNT = level_count(l - 1);

      logic  v_r;
      dist_t d_r   [CNT];
      idx_t  i_r   [CNT];
      dist_t d_nxt [CNT];
      idx_t  i_nxt [CNT];

      for (i = 0; i < CNT; i++) begin : g_pair
        if (2 * i + 1 < PCNT) begin : g_cmp
          logic pick_hi;
          // upper entry only wins when strictly closer
          assign pick_hi  = lvl_dist[l-1][2*i+1] < lvl_dist[l-1][2*i];
          assign d_nxt[i] = pick_hi ? lvl_dist[l-1][2*i+1] : lvl_dist[l-1][2*i];
          assign i_nxt[i] = pick_hi ? lvl_idx[l-1][2*i+1]  : lvl_idx[l-1][2*i];
        end else begin : g_pass
          assign d_nxt[i] = lvl_dist[l-1][2*i];
          assign i_nxt[i] = lvl_idx[l-1][2*i];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r <= 1'b0;
        end else if (lvl_rdy[l-1]) begin
          v_r <= lvl_vld[l-1];
        end
      end

      always_ff @(posedge clk) begin
        if (lvl_rdy[l-1] && lvl_vld[l-1]) begin
          d_r <= d_nxt;
          i_r <= i_nxt;
        end
      end

      assign lvl_rdy[l-1] = !v_r || lvl_rdy[l];
      assign lvl_vld[l]   = v_r;

      for (i = 0; i < NUM_ENTRIES; i++) begin : g_out
        if (i < CNT) begin : g_used
          assign lvl_dist[l][i] = d_r[i];
          assign lvl_idx[l][i]  = i_r[i];
        end else begin : g_unused
          assign lvl_dist[l][i] = '0;
          assign lvl_idx[l][i]  = '0;
        end
      end
    end
  endgenerate

  assign lvl_vld[0]         = in_valid;
  assign in_ready           = lvl_rdy[0];
  assign lvl_rdy[TREE_LVLS] = out_ready;
  assign out_valid          = lvl_vld[TREE_LVLS];
  assign out_idx            = lvl_idx[TREE_LVLS][0];
  assign out_dist           = lvl_dist[TREE_LVLS][0];

endmodule

// File: src/nearest_palette_color_core.sv
// Top level: nearest palette colour match by squared Euclidean distance
// Takes one RGB item per clock when not stalled and returns the index of the closest
// of the 20 fixed palette entries with its squared distance; on equal distances the
// lower index wins. The stages are one of channel squares, one of per-entry sums,
// one per level of the pairwise minimum tree and the output register. A new item is
// taken every cycle while nothing stalls; each stage has its own valid bit and
// stalls only when full and blocked downstream, so output back-pressure fills bubbles
// before it reaches the input.
module nearest_palette_color_core import npc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  npc_in_if.sink     in_item,
  npc_out_if.source  out_item
);

  rgb_t  in_rgb;
  logic  dist_valid;
  logic  dist_ready;
  dist_t entry_dist [NUM_ENTRIES];
  logic  best_valid;
  logic  best_ready;
  idx_t  best_idx;
  dist_t best_dist;

  logic  out_valid_r;
  idx_t  out_idx_r;
  dist_t out_dist_r;

  assign in_rgb = '{r: in_item.red, g: in_item.green, b: in_item.blue};

  npc_dist u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_item.valid),
    .in_ready   (in_item.ready),
    .in_rgb     (in_rgb),
    .dist_valid (dist_valid),
    .dist_ready (dist_ready),
    .entry_dist (entry_dist)
  );

  npc_min_tree u_min_tree (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dist_valid),
    .in_ready  (dist_ready),
    .in_dist   (entry_dist),
    .out_valid (best_valid),
    .out_ready (best_ready),
    .out_idx   (best_idx),
    .out_dist  (best_dist)
  );

  assign best_ready = !out_valid_r || out_item.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (best_ready) begin
      out_valid_r <= best_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (best_ready && best_valid) begin
      out_idx_r  <= best_idx;
      out_dist_r <= best_dist;
    end
  end

  assign out_item.valid         = out_valid_r;
  assign out_item.palette_index = out_idx_r;
  assign out_item.min_distance  = out_dist_r;

endmodule

// File: src/npc_checker.sv
// Checker on the top level ports, bound to the core
module npc_checker import npc_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input idx_t  out_palette_index,
  input dist_t out_min_distance
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic             in_acc;
  logic             out_acc;
  logic [CNT_W-1:0] pend_r;
  logic [CNT_W-1:0] pend_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) pend_nxt = pend_r + CNT_W'(1);
    if (!in_acc && out_acc) pend_nxt = pend_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_palette_index) && $stable(out_min_distance))
    else $error("result changed while stalled");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_palette_index < IDX_W'(NUM_ENTRIES))
    else $error("palette index beyond table");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result without an accepted item");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= CNT_W'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

endmodule

bind nearest_palette_color_core npc_checker u_npc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_item.valid),
  .in_ready          (in_item.ready),
  .out_valid         (out_item.valid),
  .out_ready         (out_item.ready),
  .out_palette_index (out_item.palette_index),
  .out_min_distance  (out_item.min_distance)
);
